[rtl/ptt_pkg.sv]
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and codes of the periodic timer table: input and result words,
// the stored timer slot, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

  // most results reported for one tick
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned RPT_W       = $clog2(MAX_RESULTS + 1);

  // operation codes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_SET    = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  // status codes
  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_DONE      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_FIRED     = 3'd5;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] timer_key;
    logic [15:0] interval;
    logic [15:0] fire_count;
    logic        resident;
    logic        immediate;
    logic [7:0]  callback_tag;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        fired;
    logic [15:0] result_id;
    logic [7:0]  result_tag;
    logic [15:0] ticks_left;
    logic [15:0] count_left;
    logic        last;
  } out_word_t;

  // one timer as held in the slot memory
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] interval;
    logic [15:0] countdown;
    logic [15:0] count;
    logic        resident;
    logic        immediate;
    logic [7:0]  tag;
  } slot_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

[rtl/periodic_timer_table.sv]
// ----------------------------------------------------------------------------
// periodic_timer_table
// Keyed periodic timer table: tick, set, delete and query words, with fire
// reports on ticks in slot order.
// ----------------------------------------------------------------------------
// Every input word walks all NUM_TIMERS slots through one evaluation unit:
// each slot gets a registered read of the slot memory, then the compare or
// countdown step and its write-back, which waits while the result side holds
// off a report. The next word is accepted only once the final result of the
// word has been loaded into the result register. in_ready is high only
// between words. A tick gives one fired report per firing timer (at most
// sixteen), the last one marked by last, or a single done result when
// nothing fired.
`default_nettype none

module periodic_timer_table #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ptt_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output ptt_pkg::out_word_t out_word
);

  localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

  ptt_pkg::state_t    state, state_next;
  ptt_pkg::in_word_t  item;
  logic [IDX_W-1:0]   idx;
  logic [NUM_TIMERS-1:0] slot_valid;

  // search results
  logic               found;
  logic [IDX_W-1:0]   found_idx;
  ptt_pkg::slot_t     found_slot;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;

  // held fire report, sent once the next one shows whether it is the last
  logic               pend_valid;
  ptt_pkg::out_word_t pend_word;
  logic [ptt_pkg::RPT_W-1:0] rpt_cnt;

  // memory ports
  logic               ram_wr_en;
  logic [IDX_W-1:0]   ram_wr_addr;
  ptt_pkg::slot_t     ram_wr_data;
  logic               ram_rd_en;
  ptt_pkg::slot_t     cur;

  // control
  logic               accept;
  logic               out_free;
  logic               out_load;
  ptt_pkg::out_word_t out_load_word;
  logic               step_go;
  logic               report;
  logic               finish_go;
  logic               cur_valid;
  logic               is_tick;
  logic               id_hit;

  // tick evaluation unit
  logic [15:0]        tk_cd;
  logic [15:0]        tk_cnt;
  logic               tk_fire;
  logic               tk_remove;
  ptt_pkg::slot_t     tk_slot;
  ptt_pkg::out_word_t fire_word;

  // finish results
  ptt_pkg::out_word_t fin_word;
  ptt_pkg::slot_t     set_slot;
  logic [IDX_W-1:0]   set_idx;
  logic               set_write;

  ptt_slot_ram #(
    .DEPTH  (NUM_TIMERS),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (idx),
    .rd_data (cur)
  );

  assign in_ready  = (state == ptt_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign cur_valid = slot_valid[idx];
  assign is_tick   = (item.operation == ptt_pkg::OP_TICK);
  assign id_hit    = cur_valid && (cur.id == item.timer_key);

  // countdown step of one slot
  always_comb begin
    tk_cd = cur.immediate ? 16'd0 : ((cur.countdown != 16'd0) ?
            cur.countdown - 16'd1 : 16'd0);
    tk_cnt  = cur.count;
    tk_fire = (tk_cd == 16'd0);
    if (tk_fire) begin
      tk_cd  = cur.interval;
      tk_cnt = (cur.count != 16'd0) ? cur.count - 16'd1 : 16'd0;
    end
    tk_remove = !cur.resident && (tk_cnt == 16'd0);

    tk_slot           = cur;
    tk_slot.countdown = tk_cd;
    tk_slot.count     = tk_cnt;
    tk_slot.immediate = 1'b0;

    fire_word            = '0;
    fire_word.status     = ptt_pkg::ST_FIRED;
    fire_word.fired      = 1'b1;
    fire_word.result_id  = cur.id;
    fire_word.result_tag = cur.tag;
    fire_word.ticks_left = tk_cd;
    fire_word.count_left = tk_cnt;
  end

  // final result and table write of the word
  always_comb begin
    fin_word      = '0;
    fin_word.last = 1'b1;
    set_write     = 1'b0;
    set_idx       = found ? found_idx : free_idx;

    set_slot.id        = item.timer_key;
    set_slot.interval  = item.interval;
    set_slot.countdown = item.interval;
    set_slot.count     = item.fire_count;
    set_slot.resident  = item.resident;
    set_slot.immediate = item.immediate;
    set_slot.tag       = item.callback_tag;

    unique case (item.operation)
      ptt_pkg::OP_TICK: begin
        if (pend_valid) begin
          fin_word      = pend_word;
          fin_word.last = 1'b1;
        end else begin
          fin_word.status = ptt_pkg::ST_DONE;
        end
      end
      ptt_pkg::OP_SET: begin
        set_write = found || free_found;
        fin_word.status = found ? ptt_pkg::ST_UPDATED :
                          (free_found ? ptt_pkg::ST_ADDED : ptt_pkg::ST_FULL);
      end
      ptt_pkg::OP_DELETE: begin
        fin_word.status = found ? ptt_pkg::ST_DONE : ptt_pkg::ST_NOT_FOUND;
      end
      default: begin
        if (found) begin
          fin_word.status     = ptt_pkg::ST_DONE;
          fin_word.result_id  = found_slot.id;
          fin_word.ticks_left = found_slot.countdown;
          fin_word.count_left = found_slot.count;
        end else begin
          fin_word.status = ptt_pkg::ST_NOT_FOUND;
        end
      end
    endcase
  end

  // sequencer: next state and strobes
  always_comb begin
    state_next    = state;
    ram_rd_en     = 1'b0;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = idx;
    ram_wr_data   = tk_slot;
    step_go       = 1'b0;
    finish_go     = 1'b0;
    out_load      = 1'b0;
    out_load_word = fin_word;
    report        = is_tick && cur_valid && tk_fire &&
                    (rpt_cnt < ptt_pkg::RPT_W'(ptt_pkg::MAX_RESULTS));

    unique case (state)
      ptt_pkg::S_IDLE: begin
        if (accept) begin
          state_next = ptt_pkg::S_READ;
        end
      end
      ptt_pkg::S_READ: begin
        ram_rd_en  = 1'b1;
        state_next = ptt_pkg::S_EVAL;
      end
      ptt_pkg::S_EVAL: begin
        // a held report must leave before a new one can be held
        if (!(report && pend_valid && !out_free)) begin
          step_go       = 1'b1;
          ram_wr_en     = is_tick && cur_valid;
          out_load      = report && pend_valid;
          out_load_word = pend_word;
          state_next    = (idx == LAST_IDX) ? ptt_pkg::S_FINISH : ptt_pkg::S_READ;
        end
      end
      ptt_pkg::S_FINISH: begin
        if (out_free) begin
          finish_go   = 1'b1;
          out_load    = 1'b1;
          ram_wr_en   = set_write;
          ram_wr_addr = set_idx;
          ram_wr_data = set_slot;
          state_next  = ptt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ptt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // word register and slot index
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (accept) begin
      idx <= '0;
    end else if (step_go) begin
      idx <= (idx == LAST_IDX) ? '0 : idx + 1'b1;
    end
  end

  // id search and first free slot
  always_ff @(posedge clk) begin
    if (rst) begin
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (accept) begin
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (step_go && !is_tick) begin
      if (id_hit && !found) begin
        found <= 1'b1;
      end
      if (!cur_valid && !free_found) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && !is_tick) begin
      if (id_hit && !found) begin
        found_idx  <= idx;
        found_slot <= cur;
      end
      if (!cur_valid && !free_found) begin
        free_idx <= idx;
      end
    end
  end

  // slot valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (step_go && is_tick && cur_valid && tk_remove) begin
      slot_valid[idx] <= 1'b0;
    end else if (finish_go && set_write) begin
      slot_valid[set_idx] <= 1'b1;
    end else if (finish_go && found && (item.operation == ptt_pkg::OP_DELETE)) begin
      slot_valid[found_idx] <= 1'b0;
    end
  end

  // held fire report and report count
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      rpt_cnt    <= '0;
    end else if (accept) begin
      pend_valid <= 1'b0;
      rpt_cnt    <= '0;
    end else if (step_go && report) begin
      pend_valid <= 1'b1;
      rpt_cnt    <= rpt_cnt + 1'b1;
    end else if (finish_go) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && report) begin
      pend_word <= fire_word;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word <= out_load_word;
    end
  end

`ifndef NO_ASSERTIONS
  // a held report only exists during a tick and was counted
  a_pend_tick: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (is_tick && (rpt_cnt != '0)))
    else $error("held report outside a tick or uncounted");

  // report count never passes the limit
  a_rpt_limit: assert property (@(posedge clk) disable iff (rst)
    rpt_cnt <= ptt_pkg::RPT_W'(ptt_pkg::MAX_RESULTS))
    else $error("report count beyond limit");

  // finishing a word always presents a final result
  a_finish_last: assert property (@(posedge clk) disable iff (rst)
    (state == ptt_pkg::S_FINISH && out_free) |=> (out_valid && out_word.last))
    else $error("finish without final result");

  // mid-scan reports are never marked final
  a_mid_not_last: assert property (@(posedge clk) disable iff (rst)
    (state == ptt_pkg::S_EVAL && out_load) |=> (out_valid && !out_word.last))
    else $error("intermediate report marked last");

  // slot memory is written only by the evaluate and finish steps
  a_wr_state: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> (state == ptt_pkg::S_EVAL || state == ptt_pkg::S_FINISH))
    else $error("slot write outside evaluate or finish");
`endif

endmodule

`default_nettype wire

[rtl/ptt_slot_ram.sv]
// ----------------------------------------------------------------------------
// ptt_slot_ram
// Timer slot storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_slot_ram #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  ptt_pkg::slot_t      wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output ptt_pkg::slot_t      rd_data
);

  ptt_pkg::slot_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for periodic_timer_table. A short directed run covers
// empty-table misses, zero interval, zero fire count, immediate fire, update
// by id, a full table and a sixteen-fire tick. Random timer traffic follows
// under three idling mixes, with a long result-side hold. Every result word is
// checked field by field against an in-bench model of the timer table.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NUM_SLOTS   = 16;
  localparam int ID_POOL     = 20;
  localparam int PHASE_WORDS = 102;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_WAIT  = 2 * NUM_SLOTS + 8;
  localparam int CYCLE_LIMIT = 250000;

  // timer table model and queue of result words still owed by the block
  class timer_scoreboard;
    bit                 live [NUM_SLOTS];
    ptt_pkg::slot_t     timers [NUM_SLOTS];
    ptt_pkg::out_word_t expected [$];
    int                 errors;

    function int field_diff(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        return 1;
      end
      return 0;
    endfunction

    function void push_status(logic [2:0] st);
      ptt_pkg::out_word_t r;
      r        = '0;
      r.status = st;
      r.last   = 1'b1;
      expected.push_back(r);
    endfunction

    function int find_id(logic [15:0] id);
      for (int i = 0; i < NUM_SLOTS; i++)
        if (live[i] && timers[i].id == id) return i;
      return -1;
    endfunction

    function void load(int s, ptt_pkg::in_word_t w);
      live[s]             = 1'b1;
      timers[s].id        = w.timer_key;
      timers[s].interval  = w.interval;
      timers[s].countdown = w.interval;
      timers[s].count     = w.fire_count;
      timers[s].resident  = w.resident;
      timers[s].immediate = w.immediate;
      timers[s].tag       = w.callback_tag;
    endfunction

    // apply one accepted input word and queue the results it owes
    function void note_word(ptt_pkg::in_word_t w);
      ptt_pkg::out_word_t r;
      int                 s;
      int                 free_slot;
      int                 fires;
      s         = find_id(w.timer_key);
      free_slot = -1;
      fires     = 0;
      case (w.operation)
        ptt_pkg::OP_TICK: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!live[i]) continue;
            // immediate flag wins over the countdown, which saturates at zero
            if (timers[i].immediate) begin
              timers[i].countdown = '0;
              timers[i].immediate = 1'b0;
            end else if (timers[i].countdown != 0) begin
              timers[i].countdown = timers[i].countdown - 1'b1;
            end
            if (timers[i].countdown == 0) begin
              timers[i].countdown = timers[i].interval;
              if (timers[i].count != 0) timers[i].count = timers[i].count - 1'b1;
              if (fires < ptt_pkg::MAX_RESULTS) begin
                r            = '0;
                r.status     = ptt_pkg::ST_FIRED;
                r.fired      = 1'b1;
                r.result_id  = timers[i].id;
                r.result_tag = timers[i].tag;
                r.ticks_left = timers[i].countdown;
                r.count_left = timers[i].count;
                expected.push_back(r);
                fires++;
              end
            end
            // spent one-shot style timers leave, fired or not
            if (!timers[i].resident && timers[i].count == 0) live[i] = 1'b0;
          end
          if (fires == 0) push_status(ptt_pkg::ST_DONE);
          else expected[expected.size() - 1].last = 1'b1;
        end
        ptt_pkg::OP_SET: begin
          if (s >= 0) begin
            load(s, w);
            push_status(ptt_pkg::ST_UPDATED);
          end else begin
            for (int i = NUM_SLOTS - 1; i >= 0; i--)
              if (!live[i]) free_slot = i;
            if (free_slot >= 0) begin
              load(free_slot, w);
              push_status(ptt_pkg::ST_ADDED);
            end else begin
              push_status(ptt_pkg::ST_FULL);
            end
          end
        end
        ptt_pkg::OP_DELETE: begin
          if (s < 0) begin
            push_status(ptt_pkg::ST_NOT_FOUND);
          end else begin
            live[s] = 1'b0;
            push_status(ptt_pkg::ST_DONE);
          end
        end
        default: begin
          if (s < 0) begin
            push_status(ptt_pkg::ST_NOT_FOUND);
          end else begin
            r            = '0;
            r.status     = ptt_pkg::ST_DONE;
            r.result_id  = timers[s].id;
            r.ticks_left = timers[s].countdown;
            r.count_left = timers[s].count;
            r.last       = 1'b1;
            expected.push_back(r);
          end
        end
      endcase
    endfunction

    // compare one accepted result word with the oldest one owed
    function void check_word(ptt_pkg::out_word_t got);
      ptt_pkg::out_word_t want;
      if (expected.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        errors++;
        return;
      end
      want = expected.pop_front();
      errors += field_diff("status", 16'(want.status), 16'(got.status));
      errors += field_diff("fired", 16'(want.fired), 16'(got.fired));
      errors += field_diff("result_id", want.result_id, got.result_id);
      errors += field_diff("result_tag", 16'(want.result_tag), 16'(got.result_tag));
      errors += field_diff("ticks_left", want.ticks_left, got.ticks_left);
      errors += field_diff("count_left", want.count_left, got.count_left);
      errors += field_diff("last", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic               clk;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  ptt_pkg::in_word_t  in_word   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  ptt_pkg::out_word_t out_word;

  int tx_idle       = 8;
  int rx_idle       = 51;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int cycle_count   = 0;

  logic [15:0]     id_pool [ID_POOL];
  timer_scoreboard timer_sb;

  periodic_timer_table #(
    .NUM_TIMERS(NUM_SLOTS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side: random stalls, plus one long hold when requested
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      out_ready    <= 1'b0;
      hold_left    <= LONG_HOLD;
      holds_served <= holds_served + 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) timer_sb.check_word(out_word);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** periodic_timer_table: FAILED **");
      $finish;
    end
  end

  // offer one word, hold it until accepted, then record it
  task automatic send_word(input ptt_pkg::in_word_t w);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    timer_sb.note_word(w);
  endtask

  task automatic send_op(input logic [1:0] op, input logic [15:0] id,
                         input logic [15:0] iv, input logic [15:0] cnt,
                         input logic res, input logic imm, input logic [7:0] tag);
    ptt_pkg::in_word_t w;
    w.operation    = op;
    w.timer_key    = id;
    w.interval     = iv;
    w.fire_count   = cnt;
    w.resident     = res;
    w.immediate    = imm;
    w.callback_tag = tag;
    send_word(w);
  endtask

  // mostly short intervals and counts on a small id pool so timers collide,
  // fire, expire and fill the table; now and then full-range values
  function automatic ptt_pkg::in_word_t random_word();
    ptt_pkg::in_word_t w;
    int                pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) w.operation = ptt_pkg::OP_TICK;
    else if (pick < 70) w.operation = ptt_pkg::OP_SET;
    else if (pick < 85) w.operation = ptt_pkg::OP_DELETE;
    else w.operation = ptt_pkg::OP_QUERY;
    w.timer_key    = ($urandom_range(0, 9) < 8) ? id_pool[$urandom_range(0, ID_POOL - 1)]
                                                : 16'($urandom);
    w.interval     = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 4)) : 16'($urandom);
    w.fire_count   = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 5)) : 16'($urandom);
    w.resident     = 1'($urandom_range(0, 1));
    w.immediate    = ($urandom_range(0, 3) == 0);
    w.callback_tag = 8'($urandom);
    return w;
  endfunction

  // one more set than slots, then a tick on which every timer fires and leaves
  task automatic fill_table();
    for (int i = 0; i <= NUM_SLOTS; i++)
      send_op(ptt_pkg::OP_SET, 16'($urandom), 16'($urandom_range(0, 1)), 16'd1, 1'b0,
              1'($urandom_range(0, 1)), 8'($urandom));
    send_op(ptt_pkg::OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 1'b1, 1'b1,
            8'($urandom));
  endtask

  // stop offering until every owed result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (timer_sb.expected.size() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    timer_sb = new;
    for (int i = 0; i < ID_POOL; i++) id_pool[i] = 16'($urandom);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // misses on an empty table
    send_op(ptt_pkg::OP_TICK,   16'h0000, 16'hffff, 16'hffff, 1'b1, 1'b1, 8'hff);
    send_op(ptt_pkg::OP_QUERY,  16'h1234, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00);
    send_op(ptt_pkg::OP_DELETE, 16'h1234, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00);
    // zero interval and zero count: fires once on the next tick, then leaves
    send_op(ptt_pkg::OP_SET,    16'hffff, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'hff);
    send_op(ptt_pkg::OP_QUERY,  16'hffff, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00);
    send_op(ptt_pkg::OP_TICK,   16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00);
    send_op(ptt_pkg::OP_QUERY,  16'hffff, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00);
    // full-range add, then update by id with an immediate fire
    send_op(ptt_pkg::OP_SET,    16'h0000, 16'hffff, 16'hffff, 1'b1, 1'b1, 8'h00);
    send_op(ptt_pkg::OP_QUERY,  16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00);
    send_op(ptt_pkg::OP_SET,    16'h0000, 16'h0002, 16'h0001, 1'b0, 1'b1, 8'h5a);
    send_op(ptt_pkg::OP_TICK,   16'hffff, 16'hffff, 16'hffff, 1'b0, 1'b0, 8'h00);
    // resident every-tick timer, zero-count timers, two-shot timer
    send_op(ptt_pkg::OP_SET,    16'h00a5, 16'h0001, 16'h0003, 1'b1, 1'b0, 8'ha5);
    send_op(ptt_pkg::OP_SET,    16'h5a00, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h81);
    send_op(ptt_pkg::OP_SET,    16'h0f0f, 16'h0005, 16'h0000, 1'b0, 1'b0, 8'h3c);
    send_op(ptt_pkg::OP_SET,    16'hf0f0, 16'h0002, 16'h0002, 1'b0, 1'b0, 8'hc3);
    send_op(ptt_pkg::OP_TICK,   16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00);
    send_op(ptt_pkg::OP_TICK,   16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00);
    send_op(ptt_pkg::OP_QUERY,  16'hf0f0, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00);
    send_op(ptt_pkg::OP_TICK,   16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00);
    send_op(ptt_pkg::OP_TICK,   16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00);
    send_op(ptt_pkg::OP_QUERY,  16'h00a5, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00);
    send_op(ptt_pkg::OP_DELETE, 16'h00a5, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00);
    send_op(ptt_pkg::OP_QUERY,  16'h00a5, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00);

    // sender mostly busy, receiver stalling about half the time
    fill_table();
    repeat (PHASE_WORDS - NUM_SLOTS - 2) send_word(random_word());
    drain();

    // sender gappy, receiver mostly ready
    tx_idle = 51;
    rx_idle = 8;
    repeat (PHASE_WORDS) send_word(random_word());
    drain();

    // no idling, but one long receiver hold while words keep coming
    tx_idle = 0;
    rx_idle = 0;
    hold_requests <= hold_requests + 1;
    fill_table();
    repeat (PHASE_WORDS - NUM_SLOTS - 2) send_word(random_word());
    drain();

    // catch any stray result after the last expected one
    repeat (DRAIN_WAIT) @(posedge clk);
    if (timer_sb.errors == 0 && timer_sb.expected.size() == 0) begin
      $display("** periodic_timer_table: PASSED **");
    end else begin
      $display("** periodic_timer_table: FAILED **");
    end
    $finish;
  end

endmodule
